// ----- hw/rtl/aramd_pkg.sv -----
package aramd_pkg;

	// header layout
	localparam int HEADER_BYTES = 60;
	localparam int SIZE_DIGITS  = 10;
	localparam int NAME_FIELD   = 16;
	localparam int SIZE_OFFSET  = 48;

	localparam int POS_W  = 6;
	localparam int SIZE_W = 34;
	localparam int NLEN_W = 5;
	localparam int IDX_W  = 16;
	localparam int KIND_W = 3;

	localparam logic [POS_W-1:0] POS_MAGIC_LAST = POS_W'(7);
	localparam logic [POS_W-1:0] POS_NAME_END   = POS_W'(NAME_FIELD);
	localparam logic [POS_W-1:0] POS_SIZE_BEGIN = POS_W'(SIZE_OFFSET);
	localparam logic [POS_W-1:0] POS_SIZE_END   = POS_W'(SIZE_OFFSET + SIZE_DIGITS);
	localparam logic [POS_W-1:0] POS_HDR_LAST   = POS_W'(HEADER_BYTES - 1);

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// "!<arch>\n"
	localparam logic [7:0] ARCH_MAGIC [0:7] = '{
		8'h21, 8'h3C, 8'h61, 8'h72, 8'h63, 8'h68, 8'h3E, 8'h0A
	};

	// result tags
	localparam logic [KIND_W-1:0] KIND_MAGIC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NAME    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HDR     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DATA    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PAD     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd5;

	typedef enum logic [4:0] {
		PH_MAGIC  = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_PAD    = 5'b01000,
		PH_ERROR  = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [POS_W-1:0]    position;
		logic [NLEN_W-1:0]   name_count;
		logic                name_closed;
		logic                last_was_slash;
		logic [SIZE_W-1:0]   size_acc;
		logic                digits_stopped;
		logic [SIZE_W-1:0]   data_remaining;
		logic                pad_pending;
		logic [IDX_W-1:0]    member_counter;
		logic                error_flag;
	} state_t;

	typedef struct packed {
		logic [7:0]          byte_out;
		logic [KIND_W-1:0]   kind;
		logic [IDX_W-1:0]    member_index;
		logic                header_end;
		logic [NLEN_W-1:0]   name_length;
		logic [SIZE_W-1:0]   member_size;
		logic                bad_magic;
		logic                truncated;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:          PH_MAGIC,
		position:       '0,
		name_count:     '0,
		name_closed:    1'b0,
		last_was_slash: 1'b0,
		size_acc:       '0,
		digits_stopped: 1'b0,
		data_remaining: '0,
		pad_pending:    1'b0,
		member_counter: '0,
		error_flag:     1'b0
	};

	function automatic state_t clear_header(input state_t s);
		state_t r;
		r = s;
		r.position       = '0;
		r.name_count     = '0;
		r.name_closed    = 1'b0;
		r.last_was_slash = 1'b0;
		r.size_acc       = '0;
		r.digits_stopped = 1'b0;
		return r;
	endfunction

	function automatic state_t member_done(input state_t s);
		state_t r;
		r = clear_header(s);
		r.member_counter = s.member_counter + IDX_W'(1);
		r.phase          = PH_HEADER;
		return r;
	endfunction

endpackage

// ----- hw/rtl/aramd_ifs.sv -----
interface aramd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last;

	modport source (output valid, output byte_in, output last, input ready);
	modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface aramd_result_if;
	logic                              valid;
	logic                              ready;
	logic [7:0]                        byte_out;
	logic [aramd_pkg::KIND_W-1:0]      kind;
	logic [aramd_pkg::IDX_W-1:0]       member_index;
	logic                              header_end;
	logic [aramd_pkg::NLEN_W-1:0]      name_length;
	logic [aramd_pkg::SIZE_W-1:0]      member_size;
	logic                              bad_magic;
	logic                              truncated;

	modport source (
		output valid, output byte_out, output kind, output member_index,
		output header_end, output name_length, output member_size,
		output bad_magic, output truncated, input ready
	);
	modport sink (
		input valid, input byte_out, input kind, input member_index,
		input header_end, input name_length, input member_size,
		input bad_magic, input truncated, output ready
	);
endinterface

// ----- hw/rtl/aramd_step.sv -----
module aramd_step (
	input  aramd_pkg::state_t  cur,
	input  logic [7:0]         byte_in,
	input  logic               last,
	output aramd_pkg::state_t  nxt,
	output aramd_pkg::result_t res
);

	logic [aramd_pkg::SIZE_W-1:0] dr;
	logic [aramd_pkg::SIZE_W-1:0] acc_x10;
	logic                         is_digit;

	// x*10 as two shifts and an add, kept to the accumulator width
	assign acc_x10 = {cur.size_acc[aramd_pkg::SIZE_W-4:0], 3'b000}
		+ {cur.size_acc[aramd_pkg::SIZE_W-2:0], 1'b0};
	assign is_digit = (byte_in >= aramd_pkg::CHAR_ZERO) && (byte_in <= aramd_pkg::CHAR_NINE);

	always_comb begin
		nxt              = cur;
		dr               = cur.data_remaining;
		res.byte_out     = byte_in;
		res.kind         = aramd_pkg::KIND_IGNORED;
		res.member_index = cur.member_counter;
		res.header_end   = 1'b0;
		res.name_length  = '0;
		res.member_size  = '0;
		res.bad_magic    = 1'b0;
		res.truncated    = 1'b0;

		unique case (cur.phase)
			aramd_pkg::PH_MAGIC: begin
				res.kind = aramd_pkg::KIND_MAGIC;
				if (byte_in != aramd_pkg::ARCH_MAGIC[cur.position[2:0]]) begin
					nxt.error_flag = 1'b1;
					nxt.phase      = aramd_pkg::PH_ERROR;
				end else if (cur.position >= aramd_pkg::POS_MAGIC_LAST) begin
					nxt       = aramd_pkg::clear_header(cur);
					nxt.phase = aramd_pkg::PH_HEADER;
				end else begin
					nxt.position = cur.position + aramd_pkg::POS_W'(1);
				end
			end
			aramd_pkg::PH_HEADER: begin
				res.kind = aramd_pkg::KIND_HDR;
				if (cur.position < aramd_pkg::POS_NAME_END) begin
					if (!cur.name_closed && byte_in != aramd_pkg::CHAR_SPACE) begin
						nxt.name_count     = cur.name_count + aramd_pkg::NLEN_W'(1);
						nxt.last_was_slash = (byte_in == aramd_pkg::CHAR_SLASH);
						res.kind           = aramd_pkg::KIND_NAME;
					end else begin
						nxt.name_closed = 1'b1;
					end
				end else if (cur.position >= aramd_pkg::POS_SIZE_BEGIN
						&& cur.position < aramd_pkg::POS_SIZE_END) begin
					if (!cur.digits_stopped && is_digit) begin
						nxt.size_acc = acc_x10
							+ aramd_pkg::SIZE_W'(byte_in - aramd_pkg::CHAR_ZERO);
					end else begin
						nxt.digits_stopped = 1'b1;
					end
				end
				if (cur.position >= aramd_pkg::POS_HDR_LAST) begin
					res.header_end  = 1'b1;
					res.name_length = nxt.name_count;
					if (nxt.name_count != '0 && nxt.last_was_slash) begin
						res.name_length = nxt.name_count - aramd_pkg::NLEN_W'(1);
					end
					res.member_size    = nxt.size_acc;
					nxt.data_remaining = nxt.size_acc;
					nxt.pad_pending    = nxt.size_acc[0];
					if (nxt.size_acc == '0) begin
						nxt = aramd_pkg::member_done(nxt);
					end else begin
						nxt.phase    = aramd_pkg::PH_DATA;
						nxt.position = '0;
					end
				end else begin
					nxt.position = cur.position + aramd_pkg::POS_W'(1);
				end
			end
			aramd_pkg::PH_DATA: begin
				res.kind = aramd_pkg::KIND_DATA;
				if (dr != '0) begin
					dr = dr - aramd_pkg::SIZE_W'(1);
				end
				nxt.data_remaining = dr;
				if (dr == '0) begin
					if (cur.pad_pending) begin
						nxt.phase = aramd_pkg::PH_PAD;
					end else begin
						nxt = aramd_pkg::member_done(nxt);
					end
				end
			end
			aramd_pkg::PH_PAD: begin
				res.kind        = aramd_pkg::KIND_PAD;
				nxt.pad_pending = 1'b0;
				nxt             = aramd_pkg::member_done(nxt);
			end
			default: begin
				res.kind = aramd_pkg::KIND_IGNORED;
			end
		endcase

		res.bad_magic = nxt.error_flag;
		if (last) begin
			if (nxt.phase == aramd_pkg::PH_MAGIC) begin
				res.bad_magic = 1'b1;
			end else if (nxt.phase == aramd_pkg::PH_DATA || nxt.phase == aramd_pkg::PH_PAD
					|| (nxt.phase == aramd_pkg::PH_HEADER && nxt.position != '0)) begin
				res.truncated = 1'b1;
			end
			nxt = aramd_pkg::STATE_RESET;
		end
	end

endmodule

// ----- hw/rtl/ar_archive_member_deframer_core.sv -----
// ar archive member deframer
//
// byte_ch carries the archive one byte per item (byte_in, last marks the final
// byte of a stream). result_ch gives exactly one tagged item per input byte:
// the byte itself, its kind (magic, name char, other header, data, pad or
// ignored), the member number, and on the last header byte the name length
// and decoded decimal size. bad_magic is sticky for the rest of the stream;
// truncated flags a last byte that ends inside a header, data or pad.
//
// a byte accepted from byte_ch passes two register stages, the input register
// and then the result register, before it is presented on result_ch.
// throughput: one item per cycle while result_ch is ready, set by the single
// parser state update between the two stages.
// a stalled receiver holds the result register; the input register still
// takes one more item, after which byte_ch.ready drops until space frees.
// reset (arst_n low) empties both stages and puts the parser back in the
// magic check; every byte with last set does the same for the parser state.
module ar_archive_member_deframer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	aramd_byte_if.sink            byte_ch,
	aramd_result_if.source        result_ch
);

	// parser state, only moves when an item passes into the result register
	aramd_pkg::state_t  state_q;
	aramd_pkg::state_t  state_nxt;
	aramd_pkg::result_t res_nxt;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result stage
	logic               valid_s2;
	aramd_pkg::result_t res_s2;

	logic advance;

	assign advance       = valid_s1 && (!valid_s2 || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.byte_in;
			last_s1 <= byte_ch.last;
		end
	end

	aramd_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.last    (last_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aramd_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_ch.valid        = valid_s2;
	assign result_ch.byte_out     = res_s2.byte_out;
	assign result_ch.kind         = res_s2.kind;
	assign result_ch.member_index = res_s2.member_index;
	assign result_ch.header_end   = res_s2.header_end;
	assign result_ch.name_length  = res_s2.name_length;
	assign result_ch.member_size  = res_s2.member_size;
	assign result_ch.bad_magic    = res_s2.bad_magic;
	assign result_ch.truncated    = res_s2.truncated;

	// header_end only ever falls on a plain header byte
	a_hend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.header_end |-> res_s2.kind == aramd_pkg::KIND_HDR)
		else $error("header_end on a byte that is not a plain header byte");

	// an ignored byte only follows a failed magic check
	a_ignored_bad: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == aramd_pkg::KIND_IGNORED |-> res_s2.bad_magic)
		else $error("ignored byte without bad_magic");

	// a broken stream is never also reported as truncated
	a_trunc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.truncated |-> !res_s2.bad_magic)
		else $error("truncated and bad_magic on the same item");

	// data phase always has bytes left to take
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == aramd_pkg::PH_DATA |-> state_q.data_remaining != '0)
		else $error("data phase with nothing remaining");

	// a full pipeline with a stalled receiver must back-pressure the source
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ch.ready |-> !byte_ch.ready)
		else $error("input taken while both stages are blocked");

endmodule
